>>> rtl/core/lpp_pkg.sv
`default_nettype none
package lpp_pkg;

   // Field widths
   localparam int unsigned COORD_W  = 20;
   localparam int unsigned RANGE_W  = 19;
   localparam int unsigned PIX_W    = 13;
   localparam int unsigned SIZE_W   = 14;
   localparam int unsigned COEF_W   = 32;
   localparam int unsigned COLOUR_W = 8;
   localparam int unsigned CSR_W    = 64;
   localparam int unsigned CSR_IDX_W = 3;

   // Projection arithmetic widths
   localparam int unsigned PROD_W = COEF_W + COORD_W;    // one coefficient times coordinate
   localparam int unsigned SUM_W  = PROD_W + 3;          // sum of four terms, signed
   localparam int unsigned DIV_W  = SUM_W - 1;           // positive depth magnitude
   localparam int unsigned REM_W  = DIV_W + PIX_W + 1;   // partial remainder

   // Filter bound on x: 100 m in 1/256 m
   localparam logic signed [COORD_W-1:0] X_MAX = 20'sd25600;

   // Depth index: range * 255 / 5120 == range * 51 / 1024
   localparam int unsigned DEPTH_MUL   = 51;
   localparam int unsigned DEPTH_SHIFT = 10;
   localparam int unsigned DEPTH_M_W   = RANGE_W + 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_LEFT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW0_RIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_LEFT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ROW1_RIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_LEFT  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ROW2_RIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_IMG_HEIGHT = 3'd7;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd480;

   // Jet colour map segments, selected by the top two bits of the index
   localparam logic [1:0] JET_GREEN_RISE = 2'd0;
   localparam logic [1:0] JET_BLUE_FALL  = 2'd1;
   localparam logic [1:0] JET_RED_RISE   = 2'd2;
   localparam logic [1:0] JET_GREEN_FALL = 2'd3;

   typedef logic [5:0][CSR_W-1:0] coef_bank_type;

   // Projected point handed from the multiply-accumulate stages to the divider
   typedef struct packed {
      logic signed [SUM_W-1:0] p0;
      logic signed [SUM_W-1:0] p1;
      logic signed [SUM_W-1:0] p2;
      logic                    pass;
      logic [COLOUR_W-1:0]     depth;
   } proj_type;

   // Sideband carried alongside the quotient
   typedef struct packed {
      logic                vis;
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
   } side_type;

endpackage
`default_nettype wire

>>> rtl/core/lpp_req_if.sv
`default_nettype none
interface lpp_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [lpp_pkg::COORD_W-1:0]        point_x;
   logic signed [lpp_pkg::COORD_W-1:0]        point_y;
   logic signed [lpp_pkg::COORD_W-1:0]        point_z;
   logic        [lpp_pkg::RANGE_W-1:0]        point_range;

   modport source (output valid, point_x, point_y, point_z, point_range, input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_range, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lpp_rsp_if.sv
`default_nettype none
interface lpp_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              visible;
   logic [lpp_pkg::PIX_W-1:0]         pixel_u;
   logic [lpp_pkg::PIX_W-1:0]         pixel_v;
   logic [lpp_pkg::COLOUR_W-1:0]      red;
   logic [lpp_pkg::COLOUR_W-1:0]      green;
   logic [lpp_pkg::COLOUR_W-1:0]      blue;

   modport source (output valid, visible, pixel_u, pixel_v, red, green, blue, input ready);
   modport sink   (input valid, visible, pixel_u, pixel_v, red, green, blue, output ready);
endinterface
`default_nettype wire

>>> rtl/core/lpp_mac.sv
`default_nettype none
module lpp_mac (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  en,
   input  wire logic                                  in_valid,
   input  wire logic signed [lpp_pkg::COORD_W-1:0]    point_x,
   input  wire logic signed [lpp_pkg::COORD_W-1:0]    point_y,
   input  wire logic signed [lpp_pkg::COORD_W-1:0]    point_z,
   input  wire logic        [lpp_pkg::RANGE_W-1:0]    point_range,
   input  wire lpp_pkg::coef_bank_type                coef,
   output      logic                                  out_valid,
   output      lpp_pkg::proj_type                     out_proj
);

   localparam int unsigned PW = lpp_pkg::PROD_W;
   localparam int unsigned SW = lpp_pkg::SUM_W;
   localparam int unsigned CW = lpp_pkg::COEF_W;

   logic signed [2:0][2:0][PW-1:0] prod_in, prod_ff;
   logic signed [2:0][CW+7:0]      konst_in, konst_ff;
   logic                           pass_in, pass_ff;
   logic [lpp_pkg::COLOUR_W-1:0]   depth_in, depth_ff;
   logic [lpp_pkg::DEPTH_M_W-1:0]  depth_m;
   logic [lpp_pkg::DEPTH_M_W-lpp_pkg::DEPTH_SHIFT-1:0] depth_q;
   logic                           v1_ff, v2_ff;
   lpp_pkg::proj_type              proj_in, proj_ff;

   // Multiply every coefficient by its coordinate; the constant column is one metre
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = $signed(coef[2*r][CW-1:0])    * point_x;
         prod_in[r][1] = $signed(coef[2*r][2*CW-1:CW]) * point_y;
         prod_in[r][2] = $signed(coef[2*r+1][CW-1:0])  * point_z;
         konst_in[r]   = {coef[2*r+1][2*CW-1:CW], 8'h00};
      end
   end

   // Range gate on x and depth index for the colour map
   assign pass_in = !point_x[lpp_pkg::COORD_W-1] && (point_x <= lpp_pkg::X_MAX);
   assign depth_m = lpp_pkg::DEPTH_M_W'(point_range) * lpp_pkg::DEPTH_M_W'(lpp_pkg::DEPTH_MUL);
   assign depth_q = depth_m[lpp_pkg::DEPTH_M_W-1:lpp_pkg::DEPTH_SHIFT];
   assign depth_in = (depth_q > 15'd255) ? 8'hFF : depth_q[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         konst_ff <= konst_in;
         pass_ff  <= pass_in;
         depth_ff <= depth_in;
         proj_ff  <= proj_in;
      end
   end

   // Accumulate each matrix row
   always_comb begin
      proj_in.p0 = SW'($signed(prod_ff[0][0])) + SW'($signed(prod_ff[0][1]))
                 + SW'($signed(prod_ff[0][2])) + SW'($signed(konst_ff[0]));
      proj_in.p1 = SW'($signed(prod_ff[1][0])) + SW'($signed(prod_ff[1][1]))
                 + SW'($signed(prod_ff[1][2])) + SW'($signed(konst_ff[1]));
      proj_in.p2 = SW'($signed(prod_ff[2][0])) + SW'($signed(prod_ff[2][1]))
                 + SW'($signed(prod_ff[2][2])) + SW'($signed(konst_ff[2]));
      proj_in.pass  = pass_ff;
      proj_in.depth = depth_ff;
   end

   assign out_valid = v2_ff;
   assign out_proj  = proj_ff;

endmodule
`default_nettype wire

>>> rtl/core/lpp_div.sv
`default_nettype none
module lpp_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire lpp_pkg::proj_type                in_proj,
   output      logic                             out_valid,
   output      logic [lpp_pkg::PIX_W-1:0]        out_u,
   output      logic [lpp_pkg::PIX_W-1:0]        out_v,
   output      lpp_pkg::side_type                out_side
);

   localparam int unsigned QB = lpp_pkg::PIX_W;
   localparam int unsigned DW = lpp_pkg::DIV_W;
   localparam int unsigned RW = lpp_pkg::REM_W;
   localparam int unsigned SW = lpp_pkg::SUM_W;

   logic [QB:0]                 v_ff;
   logic [QB:0][RW-1:0]         rem_u_ff, rem_v_ff;
   logic [QB:0][QB-1:0]         q_u_ff, q_v_ff;
   logic [QB:0][DW-1:0]         divs_ff;
   lpp_pkg::side_type [QB:0]    side_ff;

   logic [RW-1:0]               divs_wide;
   logic                        p2_pos, ok_u, ok_v;
   logic [RW-1:0]               dvd_u, dvd_v;
   lpp_pkg::side_type           side_in;

   // Truncating quotient fits the pixel range only when 0 <= num/den < 2^QB
   function automatic logic quot_fits(input logic signed [SW-1:0] num,
                                      input logic [RW-1:0] den);
      logic [RW-1:0] mag;
      mag = RW'($unsigned(-num));
      if (num[SW-1]) quot_fits = mag < den;
      else           quot_fits = RW'($unsigned(num)) < (den << QB);
   endfunction

   assign p2_pos    = !in_proj.p2[SW-1] && (in_proj.p2 != '0);
   assign divs_wide = RW'(in_proj.p2[DW-1:0]);
   assign ok_u      = quot_fits(in_proj.p0, divs_wide);
   assign ok_v      = quot_fits(in_proj.p1, divs_wide);
   // Small negative numerator truncates to zero
   assign dvd_u     = in_proj.p0[SW-1] ? '0 : RW'(in_proj.p0[DW-1:0]);
   assign dvd_v     = in_proj.p1[SW-1] ? '0 : RW'(in_proj.p1[DW-1:0]);

   // Jet colour map of the depth index
   always_comb begin
      logic [9:0] d4;
      d4 = {in_proj.depth, 2'b00};
      side_in.vis = in_proj.pass && p2_pos && ok_u && ok_v;
      case (in_proj.depth[7:6])
         lpp_pkg::JET_GREEN_RISE: begin
            side_in.red = 8'd0;   side_in.green = d4[7:0];  side_in.blue = 8'd255;
         end
         lpp_pkg::JET_BLUE_FALL: begin
            side_in.red = 8'd0;   side_in.green = 8'd255;
            side_in.blue = 8'(10'd510 - d4);
         end
         lpp_pkg::JET_RED_RISE: begin
            side_in.red = 8'(d4 - 10'd510); side_in.green = 8'd255; side_in.blue = 8'd0;
         end
         default: begin
            side_in.red = 8'd255; side_in.green = 8'(10'd1020 - d4); side_in.blue = 8'd0;
         end
      endcase
   end

   // Prepare stage
   always_ff @(posedge clock) begin
      if (reset) v_ff[0] <= 1'b0;
      else if (en) v_ff[0] <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_u_ff[0] <= dvd_u;
         rem_v_ff[0] <= dvd_v;
         q_u_ff[0]   <= '0;
         q_v_ff[0]   <= '0;
         divs_ff[0]  <= in_proj.p2[DW-1:0];
         side_ff[0]  <= side_in;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar i = 0; i < QB; i++) begin : g_step
      localparam int unsigned K = QB - 1 - i;
      logic [RW-1:0] sh;
      logic [RW:0]   tr_u, tr_v;

      assign sh   = RW'(divs_ff[i]) << K;
      assign tr_u = {1'b0, rem_u_ff[i]} - {1'b0, sh};
      assign tr_v = {1'b0, rem_v_ff[i]} - {1'b0, sh};

      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (en) v_ff[i+1] <= v_ff[i];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_u_ff[i+1] <= tr_u[RW] ? rem_u_ff[i] : tr_u[RW-1:0];
            rem_v_ff[i+1] <= tr_v[RW] ? rem_v_ff[i] : tr_v[RW-1:0];
            q_u_ff[i+1]   <= q_u_ff[i] | (QB'(!tr_u[RW]) << K);
            q_v_ff[i+1]   <= q_v_ff[i] | (QB'(!tr_v[RW]) << K);
            divs_ff[i+1]  <= divs_ff[i];
            side_ff[i+1]  <= side_ff[i];
         end
      end
   end

   assign out_valid = v_ff[QB];
   assign out_u     = q_u_ff[QB];
   assign out_v     = q_v_ff[QB];
   assign out_side  = side_ff[QB];

endmodule
`default_nettype wire

>>> rtl/core/lidar_point_to_pixel_projector.sv
// Throughput: one point per cycle unless the output stalls; the long pole
// is the 13-stage restoring divider, one quotient bit per stage for u and v
// side by side.
// Synchronous active-high reset clears all valid bits, the matrix to zero
// and the image size to 640 x 480.
`default_nettype none
module lidar_point_to_pixel_projector (
   input  wire logic                                clock,
   input  wire logic                                reset,
   lpp_req_if.sink                                  req,
   lpp_rsp_if.source                                rsp,
   input  wire logic                                csr_write_en,
   input  wire logic [lpp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lpp_pkg::CSR_W-1:0]           csr_wdata
);

   lpp_pkg::coef_bank_type          coef_ff;
   logic [lpp_pkg::SIZE_W-1:0]      width_ff, height_ff;
   logic                            en;
   logic                            mac_valid, div_valid;
   lpp_pkg::proj_type               mac_proj;
   logic [lpp_pkg::PIX_W-1:0]       div_u, div_v;
   lpp_pkg::side_type               div_side;
   logic                            vis_in;
   logic                            out_v_ff;
   logic                            vis_ff;
   logic [lpp_pkg::PIX_W-1:0]       u_ff, v_ff;
   logic [lpp_pkg::COLOUR_W-1:0]    red_ff, green_ff, blue_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         width_ff  <= lpp_pkg::WIDTH_RESET;
         height_ff <= lpp_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            lpp_pkg::REG_ROW0_LEFT:  coef_ff[0] <= csr_wdata;
            lpp_pkg::REG_ROW0_RIGHT: coef_ff[1] <= csr_wdata;
            lpp_pkg::REG_ROW1_LEFT:  coef_ff[2] <= csr_wdata;
            lpp_pkg::REG_ROW1_RIGHT: coef_ff[3] <= csr_wdata;
            lpp_pkg::REG_ROW2_LEFT:  coef_ff[4] <= csr_wdata;
            lpp_pkg::REG_ROW2_RIGHT: coef_ff[5] <= csr_wdata;
            lpp_pkg::REG_IMG_WIDTH:  width_ff   <= csr_wdata[lpp_pkg::SIZE_W-1:0];
            lpp_pkg::REG_IMG_HEIGHT: height_ff  <= csr_wdata[lpp_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Advance the whole pipeline unless the output holds an untaken transaction
   assign en        = !out_v_ff || rsp.ready;
   assign req.ready = en;

   lpp_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (req.valid),
      .point_x     (req.point_x),
      .point_y     (req.point_y),
      .point_z     (req.point_z),
      .point_range (req.point_range),
      .coef        (coef_ff),
      .out_valid   (mac_valid),
      .out_proj    (mac_proj)
   );

   lpp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mac_valid),
      .in_proj   (mac_proj),
      .out_valid (div_valid),
      .out_u     (div_u),
      .out_v     (div_v),
      .out_side  (div_side)
   );

   // Image bounds; pixel values never exceed 8191 so larger sizes clamp naturally
   assign vis_in = div_side.vis
                && ({1'b0, div_u} < width_ff)
                && ({1'b0, div_v} < height_ff);

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= div_valid;
   end

   // Output register; hidden points carry all-zero fields
   always_ff @(posedge clock) begin
      if (en) begin
         vis_ff   <= vis_in;
         u_ff     <= vis_in ? div_u : '0;
         v_ff     <= vis_in ? div_v : '0;
         red_ff   <= vis_in ? div_side.red   : '0;
         green_ff <= vis_in ? div_side.green : '0;
         blue_ff  <= vis_in ? div_side.blue  : '0;
      end
   end

   assign rsp.valid   = out_v_ff;
   assign rsp.visible = vis_ff;
   assign rsp.pixel_u = u_ff;
   assign rsp.pixel_v = v_ff;
   assign rsp.red     = red_ff;
   assign rsp.green   = green_ff;
   assign rsp.blue    = blue_ff;

endmodule
`default_nettype wire

>>> rtl/core/lpp_checker.sv
`default_nettype none
module lpp_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic                              visible,
   input wire logic [lpp_pkg::PIX_W-1:0]         pixel_u,
   input wire logic [lpp_pkg::PIX_W-1:0]         pixel_v,
   input wire logic [lpp_pkg::COLOUR_W-1:0]      red,
   input wire logic [lpp_pkg::COLOUR_W-1:0]      green,
   input wire logic [lpp_pkg::COLOUR_W-1:0]      blue
);

   // No result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result transaction right after reset");

   // Hidden points carry zero fields
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !visible |-> pixel_u == '0 && pixel_v == '0
                               && red == '0 && green == '0 && blue == '0)
      else $error("hidden point with non-zero fields");

   // Jet colour always saturates one channel
   a_jet_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && visible |-> red == 8'd255 || green == 8'd255 || blue == 8'd255)
      else $error("colour off the jet map");

   // Red and blue never mix in the jet map
   a_jet_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && visible |-> red == 8'd0 || blue == 8'd0)
      else $error("red and blue both lit");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(visible) && $stable(pixel_u)
                                  && $stable(pixel_v) && $stable(red)
                                  && $stable(green) && $stable(blue))
      else $error("stalled result changed");

endmodule

bind lidar_point_to_pixel_projector lpp_checker u_lpp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .visible   (rsp.visible),
   .pixel_u   (rsp.pixel_u),
   .pixel_v   (rsp.pixel_v),
   .red       (rsp.red),
   .green     (rsp.green),
   .blue      (rsp.blue)
);
`default_nettype wire
